FILE: rtl/ille_pkg.sv
package ille_pkg;

  // table depth; the request and result ports carry 6-bit indexes
  localparam int NODES = 64;

  typedef enum logic [2:0] {
    OP_MAKE    = 3'd0,
    OP_TAIL    = 3'd1,
    OP_HEAD    = 3'd2,
    OP_UNLINK  = 3'd3,
    OP_KEYINS  = 3'd4,
    OP_FIRST   = 3'd5,
    OP_LAST    = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WALK,
    S_WALKRD,
    S_W0,
    S_W1,
    S_W2,
    S_W3,
    S_DONE
  } state_t;

  localparam logic [15:0] KEY_MIN = 16'h8000;
  localparam logic [15:0] KEY_MAX = 16'h7FFF;

endpackage

FILE: rtl/indexed_linked_list_engine.sv
// Doubly linked task queues in two index tables (system, clock), each held in
// synchronous memories (next link, prev link, key) of 64 entries. One request
// is handled at a time by a sequencer that reads links, then writes them back
// in the write states W0 to W3. A make writes after its first read, tail and
// head insert after a second, unlink and remove after a third. A no-op or a
// make with no anchor slots left goes straight to done, as does a remove on an
// empty list after its second read. The sorted insert walks backward (at most
// 64 steps), each step waiting on the prev link and key reads, before its
// third read and its writes. The sequencer returns to idle after each request
// before taking the next. The result sits in its own output register, so a
// new request is taken while it waits; a finished request holds in the done
// state until that register is free. No clearing pass: entries are undefined
// until written. Anchor sentinels are allocated in pairs from entry TASKS up.
module indexed_linked_list_engine #(
  parameter int TASKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: opcode[2:0], node[8:3], anchor[14:9], key[30:15], order_sense[31]
  input  logic [31:0] s_tdata,
  // tuser: which_table
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: result_index[5:0], status[7:6]
  output logic [7:0]  m_tdata
);

  localparam int AW = $clog2(ille_pkg::NODES);
  localparam int SW = $clog2(ille_pkg::NODES + 1);
  localparam int CW = $clog2(ille_pkg::NODES + 1);

  ille_pkg::state_t state, state_next;

  // request registers
  ille_pkg::op_t   op;
  logic            tbl;
  logic [AW-1:0]   node;
  logic [AW-1:0]   anc;
  logic [15:0]     key;
  logic            asc;

  logic [SW-1:0]   slot;
  logic [AW-1:0]   a0, a1, p;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   res_idx;
  ille_pkg::status_t res_st;
  logic            busy, out_full, out_load;
  logic [7:0]      out_data;

  // memory ports
  logic [AW-1:0] nx_ra, pv_ra, ky_ra, nx_wa, pv_wa, ky_wa, nx_wd, pv_wd;
  logic [15:0]   ky_wd;
  logic          nx_we, pv_we, ky_we;
  logic [AW-1:0] snx_rd, spv_rd, cnx_rd, cpv_rd, nx_rd, pv_rd;
  logic [15:0]   sky_rd, cky_rd;
  logic          use_clk;

  assign use_clk = tbl && op != ille_pkg::OP_HEAD && op != ille_pkg::OP_KEYINS;
  assign nx_rd   = use_clk ? cnx_rd : snx_rd;
  assign pv_rd   = use_clk ? cpv_rd : spv_rd;

  ille_mem #(.NODES(ille_pkg::NODES), .AW(AW)) u_sys (
    .clk, .nx_raddr(nx_ra), .nx_rdata(snx_rd), .nx_we(nx_we && !use_clk),
    .nx_waddr(nx_wa), .nx_wdata(nx_wd), .pv_raddr(pv_ra), .pv_rdata(spv_rd),
    .pv_we(pv_we && !use_clk), .pv_waddr(pv_wa), .pv_wdata(pv_wd),
    .ky_raddr(ky_ra), .ky_rdata(sky_rd), .ky_we(ky_we && !use_clk),
    .ky_waddr(ky_wa), .ky_wdata(ky_wd)
  );

  ille_mem #(.NODES(ille_pkg::NODES), .AW(AW)) u_clk (
    .clk, .nx_raddr(nx_ra), .nx_rdata(cnx_rd), .nx_we(nx_we && use_clk),
    .nx_waddr(nx_wa), .nx_wdata(nx_wd), .pv_raddr(pv_ra), .pv_rdata(cpv_rd),
    .pv_we(pv_we && use_clk), .pv_waddr(pv_wa), .pv_wdata(pv_wd),
    .ky_raddr(ky_ra), .ky_rdata(cky_rd), .ky_we(1'b0),
    .ky_waddr(ky_wa), .ky_wdata(ky_wd)
  );

  assign busy     = state != ille_pkg::S_IDLE;
  assign s_tready = !busy;
  assign m_tvalid = out_full;
  assign m_tdata  = out_data;
  // move the finished result out once the output register is free
  assign out_load = (state == ille_pkg::S_DONE) && (!out_full || m_tready);

  logic walk_go;
  assign walk_go = ($signed(sky_rd) < $signed(key)) && cnt != CW'(ille_pkg::NODES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ille_pkg::S_IDLE:   if (s_tvalid && s_tready) state_next = ille_pkg::S_RD0;
      ille_pkg::S_RD0: begin
        unique case (op)
          ille_pkg::OP_MAKE:
            state_next = (32'(slot) + 2 > ille_pkg::NODES) ? ille_pkg::S_DONE
                                                            : ille_pkg::S_W0;
          ille_pkg::OP_NOP: state_next = ille_pkg::S_DONE;
          default:          state_next = ille_pkg::S_RD1;
        endcase
      end
      ille_pkg::S_RD1: begin
        unique case (op) inside
          ille_pkg::OP_KEYINS: state_next = ille_pkg::S_WALK;
          ille_pkg::OP_FIRST, ille_pkg::OP_LAST: begin
            state_next = (32'(op == ille_pkg::OP_FIRST ? nx_rd : pv_rd) < TASKS)
                         ? ille_pkg::S_RD2 : ille_pkg::S_DONE;
          end
          ille_pkg::OP_UNLINK: state_next = ille_pkg::S_RD2;
          default:             state_next = ille_pkg::S_W0;
        endcase
      end
      ille_pkg::S_RD2:    state_next = ille_pkg::S_W0;
      ille_pkg::S_WALK:   state_next = walk_go ? ille_pkg::S_WALKRD : ille_pkg::S_RD2;
      ille_pkg::S_WALKRD: state_next = ille_pkg::S_WALK;
      ille_pkg::S_W0:     state_next = ille_pkg::S_W1;
      ille_pkg::S_W1:     state_next = ille_pkg::S_W2;
      ille_pkg::S_W2:     state_next = ille_pkg::S_W3;
      ille_pkg::S_W3:     state_next = ille_pkg::S_DONE;
      ille_pkg::S_DONE:   state_next = out_load ? ille_pkg::S_IDLE : ille_pkg::S_DONE;
      default:            state_next = ille_pkg::S_IDLE;
    endcase
  end

  // memory read addresses and write strobes
  always_comb begin
    nx_ra = anc; pv_ra = anc; ky_ra = p;
    nx_we = 1'b0; pv_we = 1'b0; ky_we = 1'b0;
    nx_wa = node; pv_wa = node; ky_wa = node;
    nx_wd = a0; pv_wd = a0; ky_wd = key;
    unique case (state)
      ille_pkg::S_RD0: begin
        nx_ra = (op == ille_pkg::OP_UNLINK) ? node : anc;
        pv_ra = (op == ille_pkg::OP_UNLINK) ? node : anc;
      end
      ille_pkg::S_RD1: begin
        // candidate links for remove; key of tail.prev for sorted insert
        nx_ra = (op == ille_pkg::OP_FIRST) ? nx_rd : pv_rd;
        pv_ra = (op == ille_pkg::OP_FIRST) ? nx_rd : pv_rd;
        ky_ra = pv_rd;
      end
      // fetch the key of the entry just stepped to
      ille_pkg::S_WALKRD: ky_ra = pv_rd;
      ille_pkg::S_WALK:   begin pv_ra = p; nx_ra = p; end
      ille_pkg::S_RD2:    begin nx_ra = p; pv_ra = p; end
      ille_pkg::S_W0: begin
        unique case (op)
          ille_pkg::OP_MAKE: begin
            nx_we = 1'b1; nx_wa = AW'(slot); nx_wd = AW'(slot + 1'b1);
            pv_we = 1'b1; pv_wa = AW'(slot); pv_wd = AW'(slot);
            ky_we = !tbl; ky_wa = AW'(slot);
            ky_wd = asc ? ille_pkg::KEY_MIN : ille_pkg::KEY_MAX;
          end
          ille_pkg::OP_TAIL: begin
            nx_we = 1'b1; nx_wd = anc; pv_we = 1'b1; pv_wd = a0;
          end
          ille_pkg::OP_HEAD: begin
            nx_we = 1'b1; nx_wd = a0; pv_we = 1'b1; pv_wd = anc;
          end
          ille_pkg::OP_KEYINS: begin
            pv_we = 1'b1; pv_wd = p; ky_we = 1'b1;
          end
          default: begin
            // unlink and remove: links of p arrive this cycle, (p.prev).next = p.next
            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
          end
        endcase
      end
      ille_pkg::S_W1: begin
        unique case (op)
          ille_pkg::OP_MAKE: begin
            nx_we = 1'b1; nx_wa = AW'(slot + 1'b1); nx_wd = AW'(slot + 1'b1);
            pv_we = 1'b1; pv_wa = AW'(slot + 1'b1); pv_wd = AW'(slot);
            ky_we = !tbl; ky_wa = AW'(slot + 1'b1);
            ky_wd = asc ? ille_pkg::KEY_MAX : ille_pkg::KEY_MIN;
          end
          ille_pkg::OP_TAIL: begin nx_we = 1'b1; nx_wa = a0; nx_wd = node; end
          ille_pkg::OP_HEAD: begin pv_we = 1'b1; pv_wa = a0; pv_wd = node; end
          ille_pkg::OP_KEYINS: begin nx_we = 1'b1; nx_wd = a0; end
          default: begin pv_we = 1'b1; pv_wa = a0; pv_wd = a1; end
        endcase
      end
      ille_pkg::S_W2: begin
        unique case (op)
          ille_pkg::OP_TAIL: begin pv_we = 1'b1; pv_wa = anc; pv_wd = node; end
          ille_pkg::OP_HEAD: begin nx_we = 1'b1; nx_wa = anc; nx_wd = node; end
          ille_pkg::OP_KEYINS: begin nx_we = 1'b1; nx_wa = p; nx_wd = node; end
          default: ;
        endcase
      end
      ille_pkg::S_W3: begin
        if (op == ille_pkg::OP_KEYINS) begin
          pv_we = 1'b1; pv_wa = a0; pv_wd = node;
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ille_pkg::S_IDLE;
      slot <= SW'(TASKS);
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_full <= 1'b1;
      else if (m_tvalid && m_tready) out_full <= 1'b0;
      if (state == ille_pkg::S_W1 && op == ille_pkg::OP_MAKE) slot <= slot + SW'(2);
    end
  end

  // operand and link capture
  always_ff @(posedge clk) begin
    unique case (state)
      ille_pkg::S_IDLE: begin
        op  <= ille_pkg::op_t'(s_tdata[2:0]);
        tbl <= s_tuser;
        node <= s_tdata[8:3];
        anc <= s_tdata[14:9];
        key <= s_tdata[30:15];
        asc <= s_tdata[31];
        cnt <= '0;
      end
      ille_pkg::S_RD0: begin
        res_idx <= node;
        res_st  <= ille_pkg::ST_OK;
        if (op == ille_pkg::OP_MAKE) begin
          if (32'(slot) + 2 > ille_pkg::NODES) begin
            res_idx <= '0; res_st <= ille_pkg::ST_FULL;
          end else res_idx <= AW'(slot);
        end
        if (op == ille_pkg::OP_NOP) res_idx <= '0;
      end
      ille_pkg::S_RD1: begin
        unique case (op)
          ille_pkg::OP_TAIL:   a0 <= pv_rd;
          ille_pkg::OP_HEAD:   a0 <= nx_rd;
          ille_pkg::OP_UNLINK: p  <= node;
          ille_pkg::OP_KEYINS: p  <= pv_rd;
          default: begin
            p <= (op == ille_pkg::OP_FIRST) ? nx_rd : pv_rd;
            res_idx <= (op == ille_pkg::OP_FIRST) ? nx_rd : pv_rd;
            if (32'((op == ille_pkg::OP_FIRST) ? nx_rd : pv_rd) >= TASKS) begin
              res_idx <= '0; res_st <= ille_pkg::ST_EMPTY;
            end
          end
        endcase
      end
      ille_pkg::S_WALK: begin
        if (walk_go) cnt <= cnt + 1'b1;
      end
      ille_pkg::S_WALKRD: p <= pv_rd;
      ille_pkg::S_RD2: begin
        // links of p (node for unlink, candidate for remove, spot for insert)
      end
      ille_pkg::S_W0: begin
        if (op != ille_pkg::OP_TAIL && op != ille_pkg::OP_HEAD) begin
          a0 <= nx_rd; a1 <= pv_rd;
        end
      end
      ille_pkg::S_DONE: begin
        if (out_load) out_data <= {res_st, res_idx};
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/ille_mem.sv
// One table: next links, prev links and (used on the system table) keys.
// Synchronous single-port read per array, one write per array per cycle.
module ille_mem #(
  parameter int NODES = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] nx_raddr,
  output logic [AW-1:0] nx_rdata,
  input  logic          nx_we,
  input  logic [AW-1:0] nx_waddr,
  input  logic [AW-1:0] nx_wdata,
  input  logic [AW-1:0] pv_raddr,
  output logic [AW-1:0] pv_rdata,
  input  logic          pv_we,
  input  logic [AW-1:0] pv_waddr,
  input  logic [AW-1:0] pv_wdata,
  input  logic [AW-1:0] ky_raddr,
  output logic [15:0]   ky_rdata,
  input  logic          ky_we,
  input  logic [AW-1:0] ky_waddr,
  input  logic [15:0]   ky_wdata
);

  logic [AW-1:0] nx_mem [NODES];
  logic [AW-1:0] pv_mem [NODES];
  logic [15:0]   ky_mem [NODES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (ky_we) ky_mem[ky_waddr] <= ky_wdata;
    nx_rdata <= nx_mem[nx_raddr];
    pv_rdata <= pv_mem[pv_raddr];
    ky_rdata <= ky_mem[ky_raddr];
  end

endmodule

FILE: rtl/ille_checker.sv
// Port-level checks of the request/result handshake and sequencing.
module ille_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:6] != 2'd3)
    else $error("bad status code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_noimm: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too early");

endmodule

bind indexed_linked_list_engine ille_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: test/tb_indexed_linked_list_engine.sv
`timescale 1ns / 100ps

module tb_indexed_linked_list_engine;

  localparam int NODES = 64;
  localparam int TASKS = 32;
  localparam int ITEMS = 1450;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic          asc;
    logic [15:0]   key;
    logic [5:0]    anc;
    logic [5:0]    node;
    ille_pkg::op_t op;
    logic          tbl;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  indexed_linked_list_engine #(.TASKS(TASKS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Table shadow: links and keys plus a written mark per entry
  logic [5:0]  nx [0:1][0:NODES-1];
  logic [5:0]  pv [0:1][0:NODES-1];
  logic [15:0] kv [0:NODES-1];
  bit          nx_ok [0:1][0:NODES-1];
  bit          pv_ok [0:1][0:NODES-1];
  bit          kv_ok [0:NODES-1];
  logic [6:0]  anchor_slot;
  // Saved copy for rolling back a request that would read unwritten entries
  logic [5:0]  nx_s [0:1][0:NODES-1];
  logic [5:0]  pv_s [0:1][0:NODES-1];
  logic [15:0] kv_s [0:NODES-1];
  bit          nx_ok_s [0:1][0:NODES-1];
  bit          pv_ok_s [0:1][0:NODES-1];
  bit          kv_ok_s [0:NODES-1];
  logic [6:0]  anchor_slot_s;
  bit          touched_unwritten;

  // Stimulus bookkeeping: list heads per table, tasks believed queued
  logic [5:0]  heads [0:1][$];
  bit          queued [0:1][0:TASKS-1];

  logic [7:0]  expected_results [$];
  int          errors = 0;
  longint      cycles = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;

  function automatic logic [5:0] rd_next(input bit t, input logic [5:0] i);
    if (!nx_ok[t][i]) touched_unwritten = 1'b1;
    return nx[t][i];
  endfunction

  function automatic logic [5:0] rd_prev(input bit t, input logic [5:0] i);
    if (!pv_ok[t][i]) touched_unwritten = 1'b1;
    return pv[t][i];
  endfunction

  function automatic logic [15:0] rd_key(input logic [5:0] i);
    if (!kv_ok[i]) touched_unwritten = 1'b1;
    return kv[i];
  endfunction

  function automatic void wr_next(input bit t, input logic [5:0] i, input logic [5:0] v);
    nx[t][i] = v;
    nx_ok[t][i] = 1'b1;
  endfunction

  function automatic void wr_prev(input bit t, input logic [5:0] i, input logic [5:0] v);
    pv[t][i] = v;
    pv_ok[t][i] = 1'b1;
  endfunction

  function automatic void unlink_entry(input bit t, input logic [5:0] n);
    wr_next(t, rd_prev(t, n), rd_next(t, n));
    wr_prev(t, rd_next(t, n), rd_prev(t, n));
  endfunction

  function automatic void save_tables(input bit back);
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < NODES; i++) begin
        if (back) begin
          nx[t][i] = nx_s[t][i]; pv[t][i] = pv_s[t][i];
          nx_ok[t][i] = nx_ok_s[t][i]; pv_ok[t][i] = pv_ok_s[t][i];
        end else begin
          nx_s[t][i] = nx[t][i]; pv_s[t][i] = pv[t][i];
          nx_ok_s[t][i] = nx_ok[t][i]; pv_ok_s[t][i] = pv_ok[t][i];
        end
      end
    for (int i = 0; i < NODES; i++) begin
      if (back) begin
        kv[i] = kv_s[i]; kv_ok[i] = kv_ok_s[i];
      end else begin
        kv_s[i] = kv[i]; kv_ok_s[i] = kv_ok[i];
      end
    end
    if (back) anchor_slot = anchor_slot_s;
    else anchor_slot_s = anchor_slot;
  endfunction

  // Predict one request: update the tables and return {status, index}
  function automatic logic [7:0] queue_op_result(input request_t r);
    logic [5:0] h, p, n, c;
    bit t;
    t = r.tbl;
    case (r.op) inside
      ille_pkg::OP_MAKE: begin
        if (anchor_slot + 2 > NODES) return {ille_pkg::ST_FULL, 6'd0};
        h = anchor_slot[5:0];
        anchor_slot = anchor_slot + 7'd2;
        wr_next(t, h, h + 6'd1);
        wr_prev(t, h, h);
        wr_next(t, h + 6'd1, h + 6'd1);
        wr_prev(t, h + 6'd1, h);
        if (!t) begin
          kv[h] = r.asc ? ille_pkg::KEY_MIN : ille_pkg::KEY_MAX;
          kv[h + 6'd1] = r.asc ? ille_pkg::KEY_MAX : ille_pkg::KEY_MIN;
          kv_ok[h] = 1'b1;
          kv_ok[h + 6'd1] = 1'b1;
        end
        return {ille_pkg::ST_OK, h};
      end
      ille_pkg::OP_TAIL: begin
        wr_next(t, r.node, r.anc);
        wr_prev(t, r.node, rd_prev(t, r.anc));
        wr_next(t, rd_prev(t, r.anc), r.node);
        wr_prev(t, r.anc, r.node);
        return {ille_pkg::ST_OK, r.node};
      end
      ille_pkg::OP_HEAD: begin
        wr_next(0, r.node, rd_next(0, r.anc));
        wr_prev(0, r.node, r.anc);
        wr_prev(0, rd_next(0, r.anc), r.node);
        wr_next(0, r.anc, r.node);
        return {ille_pkg::ST_OK, r.node};
      end
      ille_pkg::OP_UNLINK: begin
        unlink_entry(t, r.node);
        return {ille_pkg::ST_OK, r.node};
      end
      ille_pkg::OP_KEYINS: begin
        // walk backward while the entry key is below the new key, bounded
        p = rd_prev(0, r.anc);
        for (int i = 0; i < NODES && $signed(rd_key(p)) < $signed(r.key); i++)
          p = rd_prev(0, p);
        wr_prev(0, r.node, p);
        n = rd_next(0, p);
        wr_next(0, r.node, n);
        kv[r.node] = r.key;
        kv_ok[r.node] = 1'b1;
        wr_next(0, p, r.node);
        wr_prev(0, n, r.node);
        return {ille_pkg::ST_OK, r.node};
      end
      ille_pkg::OP_FIRST, ille_pkg::OP_LAST: begin
        c = (r.op == ille_pkg::OP_FIRST) ? rd_next(t, r.anc) : rd_prev(t, r.anc);
        if (c < TASKS) begin
          unlink_entry(t, c);
          return {ille_pkg::ST_OK, c};
        end
        return {ille_pkg::ST_EMPTY, 6'd0};
      end
      default: return {ille_pkg::ST_OK, 6'd0};
    endcase
  endfunction

  // Accept a request into the prediction unless it would read unwritten entries
  function automatic bit admit_request(input request_t r);
    logic [7:0] res;
    bit t;
    save_tables(1'b0);
    touched_unwritten = 1'b0;
    res = queue_op_result(r);
    if (touched_unwritten) begin
      save_tables(1'b1);
      return 1'b0;
    end
    t = (r.op == ille_pkg::OP_HEAD || r.op == ille_pkg::OP_KEYINS) ? 1'b0 : r.tbl;
    case (r.op) inside
      ille_pkg::OP_MAKE: if (res[7:6] == ille_pkg::ST_OK) heads[t].push_back(res[5:0]);
      ille_pkg::OP_TAIL, ille_pkg::OP_HEAD, ille_pkg::OP_KEYINS:
        if (r.node < TASKS) queued[t][r.node] = 1'b1;
      ille_pkg::OP_UNLINK: if (r.node < TASKS) queued[t][r.node] = 1'b0;
      ille_pkg::OP_FIRST, ille_pkg::OP_LAST:
        if (res[7:6] == ille_pkg::ST_OK) queued[t][res[5:0]] = 1'b0;
      default: ;
    endcase
    expected_results.push_back(res);
    return 1'b1;
  endfunction

  task automatic send_request(input request_t r);
    if (!quiet && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.asc, r.key, r.anc, r.node, r.op};
    s_tuser <= r.tbl;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic issue(input ille_pkg::op_t op, input bit tbl, input logic [5:0] node,
                       input logic [5:0] anc, input logic [15:0] key, input bit asc);
    request_t r;
    r = '{asc: asc, key: key, anc: anc, node: node, op: op, tbl: tbl};
    if (admit_request(r)) send_request(r);
  endtask

  function automatic logic [5:0] pick_task(input bit t, input bit want_queued);
    logic [5:0] n;
    for (int i = 0; i < 12; i++) begin
      n = 6'($urandom_range(0, TASKS - 1));
      if (queued[t][n] == want_queued) return n;
    end
    return n;
  endfunction

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 16'h8001;
      1: return 16'h7FFE;
      default: return 16'(16'h8001 + $urandom_range(0, 65533));
    endcase
  endfunction

  // Mostly well-formed list traffic with random content, some raw noise
  function automatic request_t random_request(input bit noise);
    request_t r;
    int w;
    bit t;
    logic [5:0] h;
    r.tbl = 1'($urandom_range(0, 1));
    r.asc = 1'($urandom_range(0, 1));
    r.key = pick_key();
    r.node = 6'($urandom_range(0, NODES - 1));
    r.anc = 6'($urandom_range(0, NODES - 1));
    r.op = ille_pkg::op_t'(3'($urandom_range(0, 7)));
    if (noise) return r;
    w = $urandom_range(0, 99);
    if (w < 3) r.op = ille_pkg::OP_MAKE;
    else if (w < 25) r.op = ille_pkg::OP_TAIL;
    else if (w < 37) r.op = ille_pkg::OP_HEAD;
    else if (w < 50) r.op = ille_pkg::OP_UNLINK;
    else if (w < 68) r.op = ille_pkg::OP_KEYINS;
    else if (w < 83) r.op = ille_pkg::OP_FIRST;
    else if (w < 98) r.op = ille_pkg::OP_LAST;
    else r.op = ille_pkg::OP_NOP;
    t = (r.op == ille_pkg::OP_HEAD || r.op == ille_pkg::OP_KEYINS) ? 1'b0 : r.tbl;
    if (r.op == ille_pkg::OP_NOP || r.op == ille_pkg::OP_MAKE) return r;
    if (heads[t].size() == 0) begin
      r.op = ille_pkg::OP_MAKE;
      return r;
    end
    h = heads[t][$urandom_range(0, heads[t].size() - 1)];
    r.anc = (r.op == ille_pkg::OP_TAIL || r.op == ille_pkg::OP_KEYINS ||
             r.op == ille_pkg::OP_LAST) ? h + 6'd1 : h;
    r.node = pick_task(t, r.op == ille_pkg::OP_UNLINK);
    return r;
  endfunction

  task automatic send_random(input int count);
    request_t r;
    bit ok;
    for (int k = 0; k < count; k++) begin
      ok = 1'b0;
      for (int tries = 0; tries < 60 && !ok; tries++) begin
        r = random_request($urandom_range(0, 99) < 20);
        ok = admit_request(r);
      end
      if (!ok) begin
        r = '{asc: 1'b0, key: 16'h0, anc: 6'd0, node: 6'd0, op: ille_pkg::OP_NOP,
              tbl: 1'b0};
        ok = admit_request(r);
      end
      send_request(r);
    end
  endtask

  task automatic test_make_and_empty();
    issue(ille_pkg::OP_MAKE, 1'b0, 6'd0, 6'd0, 16'h0, 1'b1);
    issue(ille_pkg::OP_MAKE, 1'b0, 6'd0, 6'd0, 16'h0, 1'b0);
    issue(ille_pkg::OP_MAKE, 1'b1, 6'd0, 6'd0, 16'h0, 1'b1);
    issue(ille_pkg::OP_FIRST, 1'b0, 6'd0, 6'd32, 16'h0, 1'b0);
    issue(ille_pkg::OP_LAST, 1'b1, 6'd0, 6'd37, 16'h0, 1'b0);
  endtask

  task automatic test_insert_remove();
    issue(ille_pkg::OP_TAIL, 1'b1, 6'd5, 6'd37, 16'h0, 1'b0);
    issue(ille_pkg::OP_TAIL, 1'b1, 6'd31, 6'd37, 16'hFFFF, 1'b1);
    issue(ille_pkg::OP_HEAD, 1'b1, 6'd0, 6'd32, 16'h0, 1'b0);
    issue(ille_pkg::OP_UNLINK, 1'b0, 6'd0, 6'd0, 16'h0, 1'b0);
    issue(ille_pkg::OP_FIRST, 1'b1, 6'd0, 6'd36, 16'h0, 1'b0);
    issue(ille_pkg::OP_LAST, 1'b1, 6'd0, 6'd37, 16'h0, 1'b0);
  endtask

  task automatic test_sorted_insert();
    issue(ille_pkg::OP_KEYINS, 1'b0, 6'd1, 6'd35, 16'h7FFE, 1'b0);
    issue(ille_pkg::OP_KEYINS, 1'b1, 6'd2, 6'd35, 16'h8001, 1'b0);
    issue(ille_pkg::OP_KEYINS, 1'b0, 6'd3, 6'd35, 16'h0000, 1'b0);
    issue(ille_pkg::OP_LAST, 1'b0, 6'd0, 6'd35, 16'h0, 1'b0);
    // ascending list: the walk runs past the head and spins on its self link
    issue(ille_pkg::OP_KEYINS, 1'b0, 6'd4, 6'd33, 16'h0064, 1'b0);
    issue(ille_pkg::OP_FIRST, 1'b0, 6'd0, 6'd34, 16'h0, 1'b0);
    issue(ille_pkg::OP_NOP, 1'b1, 6'd63, 6'd63, 16'hFFFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    send_random(ITEMS / 3);
    quiet = 1'b1;
    send_random(200);
    quiet = 1'b0;
    send_random(ITEMS - ITEMS / 3 - 200);
  endtask

  task automatic test_output_stall();
    hold_left = 400;
    send_random(30);
  endtask

  task automatic test_anchor_exhaustion();
    for (int i = 0; i < NODES / 2 + 2; i++)
      issue(ille_pkg::OP_MAKE, i[0], 6'd0, 6'd0, 16'h0, i[1]);
    send_random(20);
  endtask

  // Result side: ready with random holds, plus a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 36);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[5:0] !== want[5:0] || m_tdata[7:6] !== want[7:6]) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("result: index exp %0d got %0d, status exp %0d got %0d",
                     want[5:0], m_tdata[5:0], want[7:6], m_tdata[7:6]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("indexed_linked_list_engine: mismatch");
      $finish;
    end
  end

  initial begin
    anchor_slot = 7'(TASKS);
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < NODES; i++) begin
        nx_ok[t][i] = 1'b0;
        pv_ok[t][i] = 1'b0;
      end
      for (int i = 0; i < TASKS; i++) queued[t][i] = 1'b0;
    end
    for (int i = 0; i < NODES; i++) kv_ok[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_make_and_empty();
    test_insert_remove();
    test_sorted_insert();
    test_random_traffic();
    test_output_stall();
    test_anchor_exhaustion();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("indexed_linked_list_engine: match");
    end else begin
      $display("indexed_linked_list_engine: mismatch");
    end
    $finish;
  end

endmodule
